/* sv/owtr_pkg.sv */
package owtr_pkg;

  // Bus phases of one command.
  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_CRST   = 4'd1,
    PH_CPRES  = 4'd2,
    PH_CWRITE = 4'd3,
    PH_WAIT   = 4'd4,
    PH_RRST   = 4'd5,
    PH_RPRES  = 4'd6,
    PH_RWRITE = 4'd7,
    PH_READ   = 4'd8
  } phase_t;

  // Command codes.
  localparam logic [1:0] OP_NONE     = 2'd0;
  localparam logic [1:0] OP_CONVERT  = 2'd1;
  localparam logic [1:0] OP_READ     = 2'd2;
  localparam logic [1:0] OP_CONV_RD  = 2'd3;

  // Bus command bytes.
  localparam logic [7:0] CMD_SKIP_ROM   = 8'hCC;
  localparam logic [7:0] CMD_CONVERT    = 8'h44;
  localparam logic [7:0] CMD_READ_SCRATCH = 8'hBE;

  // Register indexes.
  localparam logic [2:0] REG_RESET_LOW   = 3'd0;
  localparam logic [2:0] REG_PRES_SAMPLE = 3'd1;
  localparam logic [2:0] REG_PRES_TAIL   = 3'd2;
  localparam logic [2:0] REG_WRITE0_LOW  = 3'd3;
  localparam logic [2:0] REG_SHORT_LOW   = 3'd4;
  localparam logic [2:0] REG_SLOT_TOTAL  = 3'd5;
  localparam logic [2:0] REG_READ_SAMPLE = 3'd6;
  localparam logic [2:0] REG_CONV_WAIT   = 3'd7;

  localparam int CFG_DATA_W = 20;

  typedef struct packed {
    logic [9:0]  reset_low_us;
    logic [9:0]  presence_sample_us;
    logic [9:0]  presence_tail_us;
    logic [6:0]  write0_low_us;
    logic [6:0]  short_low_us;
    logic [6:0]  slot_total_us;
    logic [6:0]  read_sample_us;
    logic [19:0] conversion_wait_us;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    reset_low_us:       10'd480,
    presence_sample_us: 10'd70,
    presence_tail_us:   10'd410,
    write0_low_us:      7'd60,
    short_low_us:       7'd6,
    slot_total_us:      7'd70,
    read_sample_us:     7'd15,
    conversion_wait_us: 20'd750000
  };

  typedef struct packed {
    logic signed [15:0] temperature;
    logic               error;
    logic               done_res;
    logic               busy_res;
    logic               line_low;
  } result_t;

endpackage

/* sv/owtr_cfg.sv */
module owtr_cfg
  import owtr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RESET_LOW:   cfg.reset_low_us       <= cfg_data[9:0];
        REG_PRES_SAMPLE: cfg.presence_sample_us <= cfg_data[9:0];
        REG_PRES_TAIL:   cfg.presence_tail_us   <= cfg_data[9:0];
        REG_WRITE0_LOW:  cfg.write0_low_us      <= cfg_data[6:0];
        REG_SHORT_LOW:   cfg.short_low_us       <= cfg_data[6:0];
        REG_SLOT_TOTAL:  cfg.slot_total_us      <= cfg_data[6:0];
        REG_READ_SAMPLE: cfg.read_sample_us     <= cfg_data[6:0];
        REG_CONV_WAIT:   cfg.conversion_wait_us <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

endmodule

/* sv/owtr_core.sv */
module owtr_core
  import owtr_pkg::*;
#(
  parameter int TIMER_BITS = 20
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       step,
  input  logic [1:0] operation,
  input  logic       line_in,
  output result_t    res
);

  localparam int TB1 = TIMER_BITS + 1;
  localparam int CW  = (TIMER_BITS > 20) ? TIMER_BITS : 20;
  localparam int CW1 = CW + 1;

  phase_t                  phase, phase_next;
  logic [TIMER_BITS-1:0]   tick_count, tick_count_next;
  logic [2:0]              bit_index, bit_index_next;
  logic                    byte_index, byte_index_next;
  logic [7:0]              shift_byte, shift_byte_next;
  logic [7:0]              low_byte, low_byte_next;
  logic                    presence_seen, presence_seen_next;
  logic                    error_flag, error_flag_next;
  logic signed [15:0]      last_temperature, last_temperature_next;
  logic                    chain_read, chain_read_next;

  logic                    start, conv, drive, done;
  logic [TIMER_BITS-1:0]   tick_adv;
  logic [TB1-1:0]          tick_inc;
  logic [9:0]              reset_len, tail_len;
  logic [10:0]             pres_end;
  logic [6:0]              slot, low_time, sample_at;
  logic [CW-1:0]           wait_lim, cw_ext, tmask_ext;

  always_comb begin
    reset_len = (cfg.reset_low_us == '0) ? 10'd1 : cfg.reset_low_us;
    tail_len  = (cfg.presence_tail_us == '0) ? 10'd1 : cfg.presence_tail_us;
    slot      = (cfg.slot_total_us == '0) ? 7'd1 : cfg.slot_total_us;
    pres_end  = {1'b0, cfg.presence_sample_us} + {1'b0, tail_len};
    sample_at = (cfg.read_sample_us < slot) ? cfg.read_sample_us : slot - 7'd1;
    cw_ext    = CW'(cfg.conversion_wait_us);
    tmask_ext = CW'({TIMER_BITS{1'b1}});
    wait_lim  = (cw_ext < tmask_ext) ? cw_ext : tmask_ext;
  end

  always_comb begin
    phase_next            = phase;
    tick_count_next       = tick_count;
    bit_index_next        = bit_index;
    byte_index_next       = byte_index;
    shift_byte_next       = shift_byte;
    low_byte_next         = low_byte;
    presence_seen_next    = presence_seen;
    error_flag_next       = error_flag;
    last_temperature_next = last_temperature;
    chain_read_next       = chain_read;
    drive                 = 1'b0;
    done                  = 1'b0;
    low_time              = '0;
    conv = (phase == PH_IDLE) || (phase == PH_CRST) || (phase == PH_CPRES) ||
           (phase == PH_CWRITE) || (phase == PH_WAIT);

    // A command taken while idle starts its reset pulse on the same tick.
    start = (phase == PH_IDLE) && (operation != OP_NONE);
    if (start) begin
      chain_read_next    = (operation == OP_CONV_RD);
      phase_next         = (operation == OP_READ) ? PH_RRST : PH_CRST;
      tick_count_next    = '0;
      bit_index_next     = '0;
      byte_index_next    = 1'b0;
      presence_seen_next = 1'b0;
      conv               = (operation != OP_READ);
    end

    tick_inc = TB1'(tick_count_next) + TB1'(1);
    tick_adv = (tick_count_next == {TIMER_BITS{1'b1}}) ? tick_count_next
                                                       : tick_inc[TIMER_BITS-1:0];

    case (phase_next)
      PH_IDLE: ;
      PH_CRST, PH_RRST: begin
        drive = 1'b1;
        if (tick_inc >= TB1'(reset_len)) begin
          phase_next         = (phase_next == PH_CRST) ? PH_CPRES : PH_RPRES;
          tick_count_next    = '0;
          presence_seen_next = 1'b0;
        end else begin
          tick_count_next = tick_adv;
        end
      end
      PH_CPRES, PH_RPRES: begin
        if (tick_count_next == TIMER_BITS'(cfg.presence_sample_us)) begin
          presence_seen_next = ~line_in;
        end
        if (tick_inc >= TB1'(pres_end)) begin
          if (!presence_seen_next) begin
            error_flag_next = 1'b1;
            phase_next      = PH_IDLE;
            chain_read_next = 1'b0;
            done            = 1'b1;
          end else begin
            if (conv) begin
              error_flag_next = 1'b0;
            end
            phase_next      = (phase_next == PH_CPRES) ? PH_CWRITE : PH_RWRITE;
            tick_count_next = '0;
            bit_index_next  = '0;
            byte_index_next = 1'b0;
            shift_byte_next = CMD_SKIP_ROM;
          end
        end else begin
          tick_count_next = tick_adv;
        end
      end
      PH_CWRITE, PH_RWRITE: begin
        low_time = shift_byte_next[0] ? cfg.short_low_us : cfg.write0_low_us;
        drive    = (tick_count_next < TIMER_BITS'(low_time));
        if (tick_inc >= TB1'(slot)) begin
          tick_count_next = '0;
          shift_byte_next = {1'b0, shift_byte_next[7:1]};
          if (bit_index_next != 3'd7) begin
            bit_index_next = bit_index_next + 3'd1;
          end else begin
            bit_index_next = '0;
            if (!byte_index_next) begin
              byte_index_next = 1'b1;
              shift_byte_next = conv ? CMD_CONVERT : CMD_READ_SCRATCH;
            end else if (!conv) begin
              phase_next      = PH_READ;
              byte_index_next = 1'b0;
              shift_byte_next = '0;
            end else if (chain_read_next) begin
              phase_next = (cfg.conversion_wait_us == '0) ? PH_RRST : PH_WAIT;
            end else begin
              phase_next = PH_IDLE;
              done       = 1'b1;
            end
          end
        end else begin
          tick_count_next = tick_adv;
        end
      end
      PH_WAIT: begin
        if (CW1'(tick_inc) >= CW1'(wait_lim)) begin
          phase_next      = PH_RRST;
          tick_count_next = '0;
        end else begin
          tick_count_next = tick_adv;
        end
      end
      PH_READ: begin
        drive = (tick_count_next < TIMER_BITS'(cfg.short_low_us));
        if (tick_count_next == TIMER_BITS'(sample_at)) begin
          shift_byte_next = {line_in, shift_byte_next[7:1]};
        end
        if (tick_inc >= TB1'(slot)) begin
          tick_count_next = '0;
          if (bit_index_next != 3'd7) begin
            bit_index_next = bit_index_next + 3'd1;
          end else begin
            bit_index_next = '0;
            if (!byte_index_next) begin
              low_byte_next   = shift_byte_next;
              byte_index_next = 1'b1;
              shift_byte_next = '0;
            end else begin
              last_temperature_next = {shift_byte_next, low_byte_next};
              phase_next            = PH_IDLE;
              chain_read_next       = 1'b0;
              done                  = 1'b1;
            end
          end
        end else begin
          tick_count_next = tick_adv;
        end
      end
      default: begin
        phase_next      = PH_IDLE;
        chain_read_next = 1'b0;
      end
    endcase

    res.line_low    = drive;
    res.busy_res    = (phase_next != PH_IDLE);
    res.done_res    = done;
    res.error       = error_flag_next;
    res.temperature = last_temperature_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      tick_count       <= '0;
      bit_index        <= '0;
      byte_index       <= 1'b0;
      shift_byte       <= '0;
      low_byte         <= '0;
      presence_seen    <= 1'b0;
      error_flag       <= 1'b0;
      last_temperature <= '0;
      chain_read       <= 1'b0;
    end else if (step) begin
      phase            <= phase_next;
      tick_count       <= tick_count_next;
      bit_index        <= bit_index_next;
      byte_index       <= byte_index_next;
      shift_byte       <= shift_byte_next;
      low_byte         <= low_byte_next;
      presence_seen    <= presence_seen_next;
      error_flag       <= error_flag_next;
      last_temperature <= last_temperature_next;
      chain_read       <= chain_read_next;
    end
  end

endmodule

/* sv/onewire_temp_sensor_reader_unit.sv */
// One-wire bus master for a single temperature sensor. Every input request
// is one microsecond tick carrying the sampled line level and, while idle, a
// command (convert, read, or convert then wait then read); every request
// yields exactly one result with the line drive for that tick, busy, a done
// pulse, the sticky no-presence error and the last raw temperature in signed
// sixteenths of a degree. One request is taken every clock cycle unless the
// output is stalled: the whole tick update is a single pass through the bus
// state logic, and the result appears in the output register on the cycle
// after acceptance, so without back-pressure the sustained rate is one tick per cycle. Timing
// registers may be rewritten between commands through the write port.
module onewire_temp_sensor_reader_unit
  import owtr_pkg::*;
#(
  parameter int TIMER_BITS = 20
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // operation[1:0], line_in[2], zero pad
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [23:0]           m_tdata,   // line_low[0], busy_res[1], done_res[2],
                                           // error[3], temperature[19:4], zero pad
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg;
  result_t res, res_q;
  logic    step;

  assign s_tready = !m_tvalid || m_tready;
  assign step     = s_tvalid && s_tready;

  owtr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  owtr_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .step      (step),
    .operation (s_tdata[1:0]),
    .line_in   (s_tdata[2]),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign m_tdata = {4'd0, res_q};

endmodule
